// ----- rtl/eeic_pkg.sv -----
// Shared types and constants for the external edge interrupt controller.
// Holds the transfer payload structs, the register map and the configuration bundle.
// No dependencies.
package eeic_pkg;

	localparam int unsigned LINES      = 16;
	localparam int unsigned PORTS_MAX  = 4;
	localparam int unsigned ROUTE_W    = 4;
	localparam int unsigned GROUPS     = 7;
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned DATA_W     = 32;

	// Route nibble mask: a route field is four bits wide.
	localparam logic [ROUTE_W-1:0] ROUTE_FIELD_MASK = 4'hf;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_RISING_ENABLE    = 3'd0;
	localparam logic [2:0] REG_FALLING_ENABLE   = 3'd1;
	localparam logic [2:0] REG_LINE_UNMASK      = 3'd2;
	localparam logic [2:0] REG_ROUTE_LINES_0_7  = 3'd3;
	localparam logic [2:0] REG_ROUTE_LINES_8_15 = 3'd4;
	localparam logic [2:0] REG_GROUP_IRQ_ENABLE = 3'd5;

	// Group layout: lines 0-4 alone, then two shared groups
	localparam int unsigned SOLO_LINES   = 5;
	localparam int unsigned GRP_MID      = 5;
	localparam int unsigned GRP_HIGH     = 6;

	typedef struct packed {
		logic        func;
		logic [15:0] pins_port_a;
		logic [15:0] pins_port_b;
		logic [15:0] pins_port_c;
		logic [15:0] pins_port_d;
		logic [15:0] clear_bits;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pending_bits;
		logic [6:0]  irq_out;
	} out_item_t;

	typedef struct packed {
		logic [15:0] rising_enable;
		logic [15:0] falling_enable;
		logic [15:0] line_unmask;
		logic [31:0] route_lines_0_7;
		logic [31:0] route_lines_8_15;
		logic [6:0]  group_irq_enable;
	} cfg_t;

endpackage

// ----- rtl/eeic_regs.sv -----
// APB-style configuration register file for the edge interrupt controller.
// Depends on eeic_pkg for the register map and the cfg_t bundle.
module eeic_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eeic_pkg::ADDR_W-1:0]  paddr,
	input  logic [eeic_pkg::DATA_W-1:0]  pwdata,
	output logic [eeic_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output eeic_pkg::cfg_t               cfg
);

	eeic_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[eeic_pkg::ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				eeic_pkg::REG_RISING_ENABLE:    cfg_q.rising_enable    <= pwdata[15:0];
				eeic_pkg::REG_FALLING_ENABLE:   cfg_q.falling_enable   <= pwdata[15:0];
				eeic_pkg::REG_LINE_UNMASK:      cfg_q.line_unmask      <= pwdata[15:0];
				eeic_pkg::REG_ROUTE_LINES_0_7:  cfg_q.route_lines_0_7  <= pwdata;
				eeic_pkg::REG_ROUTE_LINES_8_15: cfg_q.route_lines_8_15 <= pwdata;
				eeic_pkg::REG_GROUP_IRQ_ENABLE: cfg_q.group_irq_enable <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			eeic_pkg::REG_RISING_ENABLE:    prdata = {16'd0, cfg_q.rising_enable};
			eeic_pkg::REG_FALLING_ENABLE:   prdata = {16'd0, cfg_q.falling_enable};
			eeic_pkg::REG_LINE_UNMASK:      prdata = {16'd0, cfg_q.line_unmask};
			eeic_pkg::REG_ROUTE_LINES_0_7:  prdata = cfg_q.route_lines_0_7;
			eeic_pkg::REG_ROUTE_LINES_8_15: prdata = cfg_q.route_lines_8_15;
			eeic_pkg::REG_GROUP_IRQ_ENABLE: prdata = {25'd0, cfg_q.group_irq_enable};
			default:                        prdata = '0;
		endcase
	end

endmodule

// ----- rtl/eeic_route.sv -----
// Per-line port selection: picks each line's pin level through its route nibble.
// Depends on eeic_pkg for in_item_t and cfg_t.
module eeic_route #(
	parameter int PORT_COUNT = 4
) (
	input  eeic_pkg::in_item_t     item,
	input  eeic_pkg::cfg_t         cfg,
	output logic [15:0]            level
);

	logic [63:0] routes;

	assign routes = {cfg.route_lines_8_15, cfg.route_lines_0_7};

	always_comb begin
		logic [eeic_pkg::ROUTE_W-1:0] code;
		code  = '0;
		level = '0;
		for (int i = 0; i < 16; i++) begin
			code = routes[i*eeic_pkg::ROUTE_W +: eeic_pkg::ROUTE_W]
				& eeic_pkg::ROUTE_FIELD_MASK;
			// codes beyond the fitted ports read low
			if (int'(code) < PORT_COUNT) begin
				case (code)
					4'd0:    level[i] = item.pins_port_a[i];
					4'd1:    level[i] = item.pins_port_b[i];
					4'd2:    level[i] = item.pins_port_c[i];
					4'd3:    level[i] = item.pins_port_d[i];
					default: level[i] = 1'b0;
				endcase
			end
		end
	end

endmodule

// ----- rtl/eeic_core.sv -----
// Edge detection, pending flags and grouped interrupt requests.
// Holds last_level and pending state plus the result register; depends on eeic_pkg.
module eeic_core #(
	parameter int LINE_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  eeic_pkg::in_item_t   item,
	input  logic [15:0]          level_raw,
	input  eeic_pkg::cfg_t       cfg,
	output eeic_pkg::out_item_t  result
);

	logic [15:0] last_level_q;
	logic [15:0] pending_q;
	logic [15:0] lines;
	logic [15:0] level;
	logic [15:0] rise, fall, hit;
	logic [15:0] pending_nxt;
	logic [15:0] act;
	logic [6:0]  req;
	eeic_pkg::out_item_t result_s2;

	always_comb begin
		for (int i = 0; i < 16; i++)
			lines[i] = (i < LINE_COUNT);
	end

	assign level = level_raw & lines;
	assign rise  = level & ~last_level_q;
	assign fall  = ~level & last_level_q;
	assign hit   = ((rise & cfg.rising_enable) | (fall & cfg.falling_enable))
		& cfg.line_unmask & lines;

	assign pending_nxt = item.func ? (pending_q & ~item.clear_bits) : (pending_q | hit);

	assign act = pending_nxt & cfg.line_unmask;
	always_comb begin
		req = '0;
		req[eeic_pkg::SOLO_LINES-1:0] = act[eeic_pkg::SOLO_LINES-1:0];
		req[eeic_pkg::GRP_MID]        = |act[9:5];
		req[eeic_pkg::GRP_HIGH]       = |act[15:10];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= '0;
			pending_q    <= '0;
		end else if (adv) begin
			pending_q <= pending_nxt;
			if (!item.func)
				last_level_q <= level;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2.pending_bits <= pending_nxt;
			result_s2.irq_out      <= req & cfg.group_irq_enable;
		end
	end

	assign result = result_s2;

endmodule

// ----- rtl/external_edge_interrupt_controller_unit.sv -----
// External edge interrupt controller, sixteen lines, seven grouped requests.
// The item passes through the input register, then the result register, which it enters
// when the output side is free; out_stall can hold it in the input register.
// Throughput: one item per cycle while out_stall is low; pending/last_level update per item.
// Reset: arst_n clears config, last_level, pending, both valid flags; not the payloads.
// Depends on eeic_pkg, eeic_regs, eeic_route and eeic_core.
module external_edge_interrupt_controller_unit #(
	parameter int LINE_COUNT = 16,
	parameter int PORT_COUNT = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  eeic_pkg::in_item_t           in_data,
	// result output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output eeic_pkg::out_item_t          out_data,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eeic_pkg::ADDR_W-1:0]  paddr,
	input  logic [eeic_pkg::DATA_W-1:0]  pwdata,
	output logic [eeic_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	eeic_pkg::cfg_t     cfg;
	eeic_pkg::in_item_t item_s1;
	logic               valid_s1;
	logic               out_valid_q;
	logic               adv;
	logic               in_take;
	logic [15:0]        level_raw;

	// Register file; only to be written while the datapath is idle; the block does not enforce it.
	eeic_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the held item into the result register whenever that register is
	// empty or its contents are being transferred out this cycle.
	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	// Hold off new input only while the stage-one item cannot move on.
	assign in_stall = valid_s1 & ~adv;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload of the input register: no reset needed.
	always_ff @(posedge clk) begin
		if (in_take)
			item_s1 <= in_data;
	end

	// Pick each line's pin level from its routed port.
	eeic_route #(
		.PORT_COUNT (PORT_COUNT)
	) u_route (
		.item  (item_s1),
		.cfg   (cfg),
		.level (level_raw)
	);

	// Edge detection, pending update and the result register.
	eeic_core #(
		.LINE_COUNT (LINE_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.level_raw (level_raw),
		.cfg       (cfg),
		.result    (out_data)
	);

	assign out_valid = out_valid_q;

endmodule
